/* hw/rtl/mcpa_pkg.sv */
// Shared types, constants and helpers of the midpoint circle address generator.
`default_nettype none

package mcpa_pkg;

    // Field widths of the input and result beats.
    localparam int unsigned COL_W      = 9;
    localparam int unsigned ROW_W      = 8;
    localparam int unsigned RAD_W      = 6;
    localparam int unsigned COLOR_W    = 8;
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned OP_W       = 8;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 136;

    // Default frame buffer line length in bytes, and the point limit per circle.
    localparam int unsigned LINE_STRIDE_DEF = 320;
    localparam int unsigned MAX_POINTS      = 47;
    localparam int unsigned COUNT_W         = 6;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CENTER,
        ST_SCALE_B,
        ST_EMIT
    } t_state;

    // Operand treatment in the shared multiplier.
    typedef enum logic {
        MUL_RAW,
        MUL_SCALED
    } t_mul_kind;

    // Request to the shared multiplier.
    typedef struct packed {
        logic              en;
        t_mul_kind         kind;
        logic [OP_W-1:0]   value;
    } t_mul_req;

    // Load command for the output register.
    typedef struct packed {
        logic load;
        logic last;
    } t_pt_load;

    // Vertical scaling by 14/16, truncating.
    function automatic logic [OP_W-1:0] scale_14_16(input logic [OP_W-1:0] v);
        logic [OP_W+3:0] t;
        t = (OP_W+4)'(v) * (OP_W+4)'(14);
        return t[OP_W+3:4];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mcpa_scale_mul.sv */
// Shared multiplier: operand (raw or scaled by 14/16) times the line stride.
`default_nettype none

module mcpa_scale_mul
    import mcpa_pkg::*;
#(
    parameter int unsigned LINE_STRIDE = LINE_STRIDE_DEF
) (
    input  wire logic              i_clk,
    input  wire t_mul_req          i_req,
    output logic [ADDR_W-1:0]      o_prod
);

    logic [OP_W-1:0]   w_op;
    logic [ADDR_W-1:0] n_prod;
    logic [ADDR_W-1:0] r_prod;

    // Select the operand and form the product modulo 65536.
    always_comb begin
        case (i_req.kind)
            MUL_SCALED: w_op = scale_14_16(i_req.value);
            MUL_RAW:    w_op = i_req.value;
            default:    w_op = i_req.value;
        endcase
        n_prod = ADDR_W'(w_op) * ADDR_W'(LINE_STRIDE);
    end

    // The product is registered before anything uses it.
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* hw/rtl/mcpa_addr_out.sv */
// Output register: mirrors one point into eight byte offsets and holds the result beat.
`default_nettype none

module mcpa_addr_out
    import mcpa_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_pt_load               i_load,
    input  wire logic [ADDR_W-1:0]      i_center,
    input  wire logic [RAD_W-1:0]       i_a,
    input  wire logic [RAD_W-1:0]       i_b,
    input  wire logic [ADDR_W-1:0]      i_sa,
    input  wire logic [ADDR_W-1:0]      i_sb,
    input  wire logic [COLOR_W-1:0]     i_color,
    output logic                        o_free,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [OUT_DATA_W-1:0]       o_data,
    output logic                        o_last
);

    logic [ADDR_W-1:0]     w_cap;
    logic [ADDR_W-1:0]     w_cam;
    logic [ADDR_W-1:0]     w_cbp;
    logic [ADDR_W-1:0]     w_cbm;
    logic [OUT_DATA_W-1:0] n_data;
    logic [OUT_DATA_W-1:0] r_data;
    logic                  r_valid;
    logic                  r_last;

    // Eight mirrored offsets, all wrapping modulo 65536.
    always_comb begin
        w_cap  = i_center + ADDR_W'(i_a);
        w_cam  = i_center - ADDR_W'(i_a);
        w_cbp  = i_center + ADDR_W'(i_b);
        w_cbm  = i_center - ADDR_W'(i_b);
        n_data = {i_color,
                  w_cbm - i_sa, w_cbm + i_sa, w_cbp - i_sa, w_cbp + i_sa,
                  w_cam - i_sb, w_cam + i_sb, w_cap - i_sb, w_cap + i_sb};
    end

    // The register may take a new beat when empty or when its beat leaves now.
    assign o_free = !r_valid || i_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Beat payload.
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_data <= n_data;
            r_last <= i_load.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

`default_nettype wire

/* hw/rtl/midpoint_circle_pixel_addresses.sv */
// Top level: circle command sequencer with midpoint stepping and the shared stride multiplier.
`default_nettype none

// Takes one circle command (center column, center row, radius, pen color) and
// emits one result beat per plotted point of the midpoint circle octant walk,
// each carrying eight mirrored byte offsets into a frame buffer of
// LINE_STRIDE-byte lines, the pen color, and tlast on the final point. A
// single multiplier by the line stride is shared by the center row and the
// 14/16-scaled row of both coordinates. A command steps through ST_CENTER and
// ST_SCALE_B, then alternates ST_EMIT and ST_SCALE_B for each point (at most
// 47 points); a stall on the result side holds ST_EMIT. The input is ready only
// while no command is being stepped; the last point may still wait in the
// output register while the next command is taken.
module midpoint_circle_pixel_addresses
    import mcpa_pkg::*;
#(
    parameter int unsigned LINE_STRIDE = LINE_STRIDE_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // center_col[8:0], center_row[16:9], radius[22:17], pen_color[30:23], zero[31]
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // addr_pp[15:0], addr_pm[31:16], addr_mp[47:32], addr_mm[63:48],
    // addr_swap_pp[79:64], addr_swap_pm[95:80], addr_swap_mp[111:96],
    // addr_swap_mm[127:112], pixel_color[135:128]
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    // last_point
    output logic                        m_axis_tlast
);

    logic [COL_W-1:0]     w_in_col;
    logic [ROW_W-1:0]     w_in_row;
    logic [RAD_W-1:0]     w_in_rad;
    logic [COLOR_W-1:0]   w_in_color;
    logic                 w_s_accept;

    t_state               r_state, n_state;
    logic [COL_W-1:0]     r_col, n_col;
    logic [COLOR_W-1:0]   r_color, n_color;
    logic [ADDR_W-1:0]    r_center, n_center;
    logic [ADDR_W-1:0]    r_sa, n_sa;
    logic [RAD_W-1:0]     r_a, n_a;
    logic [RAD_W-1:0]     r_b, n_b;
    logic signed [9:0]    r_d, n_d;
    logic [7:0]           r_e, n_e;
    logic signed [8:0]    r_se, n_se;
    logic                 r_dec, n_dec;
    logic [COUNT_W-1:0]   r_count, n_count;

    logic [RAD_W-1:0]     w_b1;
    logic                 w_cont;
    logic [7:0]           w_e2;
    logic signed [8:0]    w_se1;
    logic                 w_free;
    logic [ADDR_W-1:0]    w_prod;
    t_mul_req             w_mul_req;
    t_pt_load             w_load;

    // Unpack the command beat.
    assign w_in_col   = s_axis_tdata[8:0];
    assign w_in_row   = s_axis_tdata[16:9];
    assign w_in_rad   = s_axis_tdata[22:17];
    assign w_in_color = s_axis_tdata[30:23];
    assign w_s_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Shared stride multiplier.
    mcpa_scale_mul #(
        .LINE_STRIDE (LINE_STRIDE)
    ) u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    // Output register and address mirroring.
    mcpa_addr_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_center (r_center),
        .i_a      (r_a),
        .i_b      (r_b),
        .i_sa     (r_sa),
        .i_sb     (w_prod),
        .i_color  (r_color),
        .o_free   (w_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

    // Sequencer: next state, stepping and multiplier requests.
    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_color   = r_color;
        n_center  = r_center;
        n_sa      = r_sa;
        n_a       = r_a;
        n_b       = r_b;
        n_d       = r_d;
        n_e       = r_e;
        n_se      = r_se;
        n_dec     = r_dec;
        n_count   = r_count;
        w_mul_req = '{en: 1'b1, kind: MUL_SCALED, value: '0};
        w_load    = '{load: 1'b0, last: 1'b0};

        // A south-east move lowers the row only after its point is out.
        w_b1   = r_dec ? r_b - RAD_W'(1) : r_b;
        w_cont = (w_b1 > r_a) && (r_count < COUNT_W'(MAX_POINTS));
        w_e2   = r_e + 8'd2;
        w_se1  = r_se + 9'sd2;

        case (r_state)
            ST_IDLE: begin
                // The row product is ready at the edge that takes the command.
                w_mul_req = '{en: 1'b1, kind: MUL_RAW, value: OP_W'(w_in_row)};
                if (w_s_accept) begin
                    n_col   = w_in_col;
                    n_color = w_in_color;
                    n_a     = '0;
                    n_b     = w_in_rad;
                    n_d     = 10'sd1 - $signed({4'b0, w_in_rad});
                    n_e     = 8'd3;
                    n_se    = 9'sd5 - $signed({2'b0, w_in_rad, 1'b0});
                    n_dec   = 1'b0;
                    n_count = COUNT_W'(1);
                    n_state = ST_CENTER;
                end
            end
            ST_CENTER: begin
                n_center  = ADDR_W'(r_col) + w_prod;
                w_mul_req = '{en: 1'b1, kind: MUL_SCALED, value: OP_W'(r_a)};
                n_state   = ST_SCALE_B;
            end
            ST_SCALE_B: begin
                n_sa      = w_prod;
                w_mul_req = '{en: 1'b1, kind: MUL_SCALED, value: OP_W'(r_b)};
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                // While the result side stalls, the scaled row is held.
                w_mul_req = '{en: w_free, kind: MUL_SCALED, value: OP_W'(r_a + RAD_W'(1))};
                if (w_free) begin
                    w_load = '{load: 1'b1, last: !w_cont};
                    if (w_cont) begin
                        n_a     = r_a + RAD_W'(1);
                        n_b     = w_b1;
                        n_e     = w_e2;
                        n_count = r_count + COUNT_W'(1);
                        if (r_d[9]) begin
                            n_d   = r_d + $signed({2'b0, w_e2});
                            n_se  = w_se1;
                            n_dec = 1'b0;
                        end else begin
                            n_d   = r_d + $signed({w_se1[8], w_se1});
                            n_se  = w_se1 + 9'sd2;
                            n_dec = 1'b1;
                        end
                        n_state = ST_SCALE_B;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and stepping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_a     <= '0;
            r_b     <= '0;
            r_d     <= '0;
            r_e     <= '0;
            r_se    <= '0;
            r_dec   <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_b     <= n_b;
            r_d     <= n_d;
            r_e     <= n_e;
            r_se    <= n_se;
            r_dec   <= n_dec;
            r_count <= n_count;
        end
    end

    // Command payload registers.
    always_ff @(posedge i_clk) begin
        r_col    <= n_col;
        r_color  <= n_color;
        r_center <= n_center;
        r_sa     <= n_sa;
    end

`ifndef SYNTH
    // A taken command blocks the input on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> !s_axis_tready)
        else $error("input ready right after a command was taken");

    // Every emitted point lies in the octant above the diagonal.
    a_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_a <= r_b))
        else $error("stepped point left the octant");

    // Finishing a circle leaves its final point waiting with tlast.
    a_last_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && $past(r_state) == ST_EMIT) |-> (m_axis_tvalid && m_axis_tlast))
        else $error("circle finished without a last point");

    // The point count never passes the limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_count <= COUNT_W'(MAX_POINTS) && r_count != '0))
        else $error("point count out of range");
`endif

endmodule

`default_nettype wire
